// ----- src/htps_pkg.sv -----
`timescale 1ns / 1ps

package htps_pkg;

  localparam int AMB_W     = 16;
  localparam int MASS_W    = 16;
  localparam int TICK_W    = 20;
  localparam int DUTY_W    = 16;
  localparam int TEMP_W    = 32;
  localparam int CODE_W    = 12;
  localparam int Q8_W      = 16;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;
  localparam int PC_W      = 4;
  localparam int CNT_W     = 6;
  localparam int DEN_W     = 40;
  localparam int PROD_W    = 55;
  localparam int NET_W     = 35;

  localparam logic [DUTY_W-1:0]        DUTY_KEEP  = 16'd62259;
  localparam logic [DUTY_W-1:0]        DUTY_ADD   = 16'd3277;
  localparam logic [6:0]               HEAT_GAIN  = 7'd120;
  localparam logic [MASS_W-1:0]        MASS_MIN   = 16'd256;
  localparam logic [23:0]              DEN_SCALE  = 24'd11250000;
  localparam logic signed [TEMP_W-1:0] TEMP_TOP   = 32'sd3932160;
  localparam logic [33:0]              DAC_HALF   = 34'd1966080;
  localparam logic [16:0]              DAC_RECIP  = 17'd69906;
  localparam logic [CODE_W-1:0]        DAC_FULL   = 12'd4095;
  localparam logic signed [TEMP_W-1:0] TEMP_RESET = 32'sh0019_0000;
  localparam logic signed [AMB_W-1:0]  AMB_RESET  = 16'sd6400;
  localparam logic [MASS_W-1:0]        MASS_RESET = 16'd512;
  localparam logic [TICK_W-1:0]        TICK_RESET = 20'd5000;
  localparam logic [CNT_W-1:0]         ITER_TEMP  = 6'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_AMBIENT = 2'd0,
    CFG_MASS    = 2'd1,
    CFG_TICK    = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_DUTY,
    OP_NET,
    OP_MULNET,
    OP_LDDIV_T,
    OP_DIVSTEP,
    OP_UPDATE,
    OP_MULDAC,
    OP_DACSCALE,
    OP_EMIT,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_NO_INPUT,
    JC_DIV_BUSY,
    JC_OUT_BUSY
  } jc_e;

  typedef struct packed {
    op_e             op;
    jc_e             jc;
    logic [PC_W-1:0] target;
  } ctrl_t;

  localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [PC_W-1:0] STEP_DIV_T = 4'd5;
  localparam logic [PC_W-1:0] STEP_EMIT  = 4'd9;

  function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
    ctrl_t c;
    case (pc)
      4'd0:    c = '{op: OP_ACCEPT,   jc: JC_NO_INPUT, target: STEP_IDLE};
      4'd1:    c = '{op: OP_DUTY,     jc: JC_NEVER,    target: STEP_IDLE};
      4'd2:    c = '{op: OP_NET,      jc: JC_NEVER,    target: STEP_IDLE};
      4'd3:    c = '{op: OP_MULNET,   jc: JC_NEVER,    target: STEP_IDLE};
      4'd4:    c = '{op: OP_LDDIV_T,  jc: JC_NEVER,    target: STEP_IDLE};
      4'd5:    c = '{op: OP_DIVSTEP,  jc: JC_DIV_BUSY, target: STEP_DIV_T};
      4'd6:    c = '{op: OP_UPDATE,   jc: JC_NEVER,    target: STEP_IDLE};
      4'd7:    c = '{op: OP_MULDAC,   jc: JC_NEVER,    target: STEP_IDLE};
      4'd8:    c = '{op: OP_DACSCALE, jc: JC_NEVER,    target: STEP_IDLE};
      4'd9:    c = '{op: OP_EMIT,     jc: JC_OUT_BUSY, target: STEP_EMIT};
      default: c = '{op: OP_NOP,      jc: JC_ALWAYS,   target: STEP_IDLE};
    endcase
    return c;
  endfunction

endpackage

// ----- src/heater_thermal_plant_step.sv -----
`timescale 1ns / 1ps

// Heater plant model that advances one step for each input transfer: the PWM sample updates
// the smoothed duty, the chamber temperature moves by the net heater power over the thermal
// mass, and one result transfer carries the DAC code, the Q8.8 temperature and the duty.
// The temperature change is found by a bit-serial divider of 32 iterations and the DAC
// code is scaled by a reciprocal multiplication. After the step has handed its result to
// the output register it passes an idle step before it takes the next input, so a new
// input is never taken while a step is in progress, and a result still waiting in the
// output register holds the step at its last stage.
// Configuration writes must only be made while no step is in progress.
module heater_thermal_plant_step_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [htps_pkg::CFG_IDX_W-1:0]     cfg_addr_i,
  input  logic [htps_pkg::CFG_W-1:0]         cfg_wdata_i,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [7:0]                         s_axis_tdata_i,  // [0] pwm_level
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [11:0] dac_code, [27:12] plant_temp, [43:28] duty_level
  output logic [47:0]                        m_axis_tdata_o
);

  import htps_pkg::*;

  ctrl_t                      ctrl;
  logic [PC_W-1:0]            pc_q, pc_d;
  logic                       jump;
  logic                       out_free;

  logic signed [AMB_W-1:0]    amb_q, amb_d;
  logic [MASS_W-1:0]          mass_q, mass_d;
  logic [TICK_W-1:0]          tick_q, tick_d;

  logic                       sample_q, sample_d;
  logic [DUTY_W-1:0]          duty_q, duty_d;
  logic signed [TEMP_W-1:0]   temp_q, temp_d;
  logic [PROD_W-1:0]          prod_q, prod_d;
  logic [NET_W-1:0]           netmag_q, netmag_d;
  logic                       netneg_q, netneg_d;
  logic [DEN_W-1:0]           den_q, den_d;
  logic [DEN_W-1:0]           rem_q, rem_d;
  logic [31:0]                quo_q, quo_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;

  logic                       mvalid_q, mvalid_d;
  logic [43:0]                mdata_q, mdata_d;

  logic [MASS_W-1:0]          mass_c;
  logic [32:0]                duty_rnd;
  logic [17:0]                duty_sum;
  logic [22:0]                heat;
  logic signed [33:0]         amb_ext;
  logic signed [33:0]         diff;
  logic signed [35:0]         net_s;
  logic [60:0]                div_t_in;
  logic [33:0]                div_d_in;
  logic [40:0]                rshift;
  logic                       ge;
  logic signed [33:0]         tsum;
  logic [21:0]                tlim;
  logic [CODE_W-1:0]          code;
  logic [23:0]                t8;
  logic [Q8_W-1:0]            q8;

  assign ctrl            = ucode(pc_q);
  assign out_free        = !mvalid_q || m_axis_tready_i;
  assign s_axis_tready_o = (ctrl.op == OP_ACCEPT);
  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {4'b0000, mdata_q};

  // The DAC divisor is 15 * 2^18: a shift by 18, then a reciprocal multiplication for 15.
  always_comb begin
    mass_c   = (mass_q < MASS_MIN) ? MASS_MIN : mass_q;
    duty_rnd = {1'b0, prod_q[31:0]} + 33'd32768;
    duty_sum = {1'b0, duty_rnd[32:16]} + (sample_q ? {2'b00, DUTY_ADD} : 18'd0);
    heat     = 23'(duty_q) * 23'(HEAT_GAIN);
    amb_ext  = 34'($signed({amb_q, 8'h00}));
    diff     = 34'(temp_q) - amb_ext;
    net_s    = $signed({13'b0, heat}) - $signed({diff, 2'b00});
    div_t_in = {prod_q, 6'b000000} + 61'(den_q[DEN_W-1:1]);
    div_d_in = prod_q[33:0] + DAC_HALF;
    rshift   = {rem_q, quo_q[31]};
    ge       = rshift >= {1'b0, den_q};
    tsum     = 34'(temp_q) + (netneg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}));
    tlim     = (temp_q > 32'sd0 && temp_q < TEMP_TOP) ? temp_q[21:0] : 22'd0;
    if (temp_q <= 32'sd0) begin
      code = '0;
    end else if (temp_q >= TEMP_TOP) begin
      code = DAC_FULL;
    end else begin
      code = prod_q[CODE_W+19:20];
    end
    t8 = temp_q[31:8];
    if (t8[23:15] == 9'h000 || t8[23:15] == 9'h1FF) begin
      q8 = t8[15:0];
    end else if (t8[23]) begin
      q8 = 16'h8000;
    end else begin
      q8 = 16'h7FFF;
    end
  end

  always_comb begin
    case (ctrl.jc)
      JC_ALWAYS:   jump = 1'b1;
      JC_NO_INPUT: jump = !s_axis_tvalid_i;
      JC_DIV_BUSY: jump = (cnt_q != 6'd1);
      JC_OUT_BUSY: jump = !out_free;
      default:     jump = 1'b0;
    endcase
    pc_d = jump ? ctrl.target : pc_q + 4'd1;
  end

  always_comb begin
    amb_d    = amb_q;
    mass_d   = mass_q;
    tick_d   = tick_q;
    sample_d = sample_q;
    duty_d   = duty_q;
    temp_d   = temp_q;
    prod_d   = prod_q;
    netmag_d = netmag_q;
    netneg_d = netneg_q;
    den_d    = den_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    cnt_d    = cnt_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;

    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_AMBIENT: amb_d  = $signed(cfg_wdata_i[AMB_W-1:0]);
        CFG_MASS:    mass_d = cfg_wdata_i[MASS_W-1:0];
        CFG_TICK:    tick_d = cfg_wdata_i;
        default:     ;
      endcase
    end

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    case (ctrl.op)
      OP_ACCEPT: begin
        if (s_axis_tvalid_i) begin
          sample_d = s_axis_tdata_i[0];
          prod_d   = PROD_W'(32'(duty_q) * 32'(DUTY_KEEP));
        end
      end
      OP_DUTY: begin
        duty_d = (duty_sum > 18'd65535) ? 16'hFFFF : duty_sum[15:0];
        den_d  = DEN_W'(mass_c) * DEN_W'(DEN_SCALE);
      end
      OP_NET: begin
        netneg_d = net_s[35];
        netmag_d = net_s[35] ? NET_W'(-net_s) : net_s[NET_W-1:0];
      end
      OP_MULNET: begin
        prod_d = PROD_W'(netmag_q) * PROD_W'(tick_q);
      end
      OP_LDDIV_T: begin
        rem_d = DEN_W'(div_t_in[60:32]);
        quo_d = div_t_in[31:0];
        cnt_d = ITER_TEMP;
      end
      OP_DIVSTEP: begin
        rem_d = ge ? DEN_W'(rshift - {1'b0, den_q}) : rshift[DEN_W-1:0];
        quo_d = {quo_q[30:0], ge};
        cnt_d = cnt_q - 6'd1;
      end
      OP_UPDATE: begin
        if (tsum[33:31] == 3'b000 || tsum[33:31] == 3'b111) begin
          temp_d = tsum[31:0];
        end else if (tsum[33]) begin
          temp_d = 32'sh8000_0000;
        end else begin
          temp_d = 32'sh7FFF_FFFF;
        end
      end
      OP_MULDAC: begin
        prod_d = PROD_W'(34'(tlim) * 34'(DAC_FULL));
      end
      OP_DACSCALE: begin
        prod_d = PROD_W'(div_d_in[33:18]) * PROD_W'(DAC_RECIP);
      end
      OP_EMIT: begin
        if (out_free) begin
          mvalid_d = 1'b1;
          mdata_d  = {duty_q, q8, code};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= STEP_IDLE;
      amb_q    <= AMB_RESET;
      mass_q   <= MASS_RESET;
      tick_q   <= TICK_RESET;
      sample_q <= 1'b0;
      duty_q   <= '0;
      temp_q   <= TEMP_RESET;
      prod_q   <= '0;
      netmag_q <= '0;
      netneg_q <= 1'b0;
      den_q    <= '0;
      rem_q    <= '0;
      quo_q    <= '0;
      cnt_q    <= '0;
      mvalid_q <= 1'b0;
      mdata_q  <= '0;
    end else begin
      pc_q     <= pc_d;
      amb_q    <= amb_d;
      mass_q   <= mass_d;
      tick_q   <= tick_d;
      sample_q <= sample_d;
      duty_q   <= duty_d;
      temp_q   <= temp_d;
      prod_q   <= prod_d;
      netmag_q <= netmag_d;
      netneg_q <= netneg_d;
      den_q    <= den_d;
      rem_q    <= rem_d;
      quo_q    <= quo_d;
      cnt_q    <= cnt_d;
      mvalid_q <= mvalid_d;
      mdata_q  <= mdata_d;
    end
  end

endmodule

// ----- bench/heater_thermal_plant_step_core_tb.sv -----
`timescale 1ns / 1ps

module heater_thermal_plant_step_core_tb;
  import htps_pkg::*;

  typedef struct {
    logic [CODE_W-1:0]        dac_code;
    logic signed [Q8_W-1:0]   plant_temp;
    logic [DUTY_W-1:0]        duty_level;
  } plant_reading_t;

  class plant_tracker;
    logic signed [AMB_W-1:0]  ambient;
    logic [MASS_W-1:0]        mass;
    logic [TICK_W-1:0]        tick_us;
    logic [DUTY_W-1:0]        duty;
    logic signed [TEMP_W-1:0] temp_acc;
    plant_reading_t           pending_readings[$];
    int                       errors;
    int                       ticks_seen;
    int                       readings_seen;

    function new();
      ambient       = AMB_RESET;
      mass          = MASS_RESET;
      tick_us       = TICK_RESET;
      duty          = '0;
      temp_acc      = TEMP_RESET;
      errors        = 0;
      ticks_seen    = 0;
      readings_seen = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [CFG_W-1:0] value);
      case (idx)
        CFG_AMBIENT: ambient = value[AMB_W-1:0];
        CFG_MASS:    mass    = value[MASS_W-1:0];
        CFG_TICK:    tick_us = value[TICK_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the plant by one tick and queues the reading it should report.
    function void advance_plant(bit pwm);
      longint d, amb_q16, heat, net, num, den, mag, dtemp, t, code, q8;
      longint eff_mass;
      plant_reading_t r;
      d = (longint'(duty) * 62259 + 32768) >>> 16;
      if (pwm) d = d + 3277;
      if (d > 65535) d = 65535;
      duty = d[DUTY_W-1:0];

      amb_q16  = longint'(ambient) * 256;
      heat     = 120 * longint'(duty);
      net      = heat - 4 * (longint'(temp_acc) - amb_q16);
      eff_mass = (mass < 256) ? 256 : longint'(mass);
      num      = net * longint'(tick_us) * 64;
      den      = 45 * eff_mass * 250000;
      mag      = (num < 0) ? -num : num;
      dtemp    = (mag + den / 2) / den;
      if (num < 0) dtemp = -dtemp;
      t = longint'(temp_acc) + dtemp;
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      temp_acc = t[TEMP_W-1:0];

      if (t <= 0) begin
        code = 0;
      end else begin
        code = (t * 4095 + 1966080) / 3932160;
        if (code > 4095) code = 4095;
      end
      q8 = t >>> 8;
      if (q8 > 32767) q8 = 32767;
      if (q8 < -32768) q8 = -32768;

      r.dac_code     = code[CODE_W-1:0];
      r.plant_temp   = q8[Q8_W-1:0];
      r.duty_level   = duty;
      pending_readings.push_back(r);
      ticks_seen++;
    endfunction

    function void check_result(logic [47:0] data);
      plant_reading_t want;
      readings_seen++;
      if (pending_readings.size() == 0) begin
        $error("result transfer with no reading waiting: tdata=%h", data);
        errors++;
        return;
      end
      want = pending_readings.pop_front();
      if (data[11:0] !== want.dac_code) begin
        $error("dac_code: expected %0d, got %0d", want.dac_code, data[11:0]);
        errors++;
      end
      if (data[27:12] !== want.plant_temp) begin
        $error("plant_temp: expected %0d, got %0d", want.plant_temp,
               $signed(data[27:12]));
        errors++;
      end
      if (data[43:28] !== want.duty_level) begin
        $error("duty_level: expected %0d, got %0d", want.duty_level, data[43:28]);
        errors++;
      end
    endfunction

    function int pending();
      return pending_readings.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_n      = 1'b0;
  logic                 cfg_we     = 1'b0;
  cfg_idx_e             cfg_addr   = CFG_AMBIENT;
  logic [CFG_W-1:0]     cfg_wdata  = '0;
  logic                 s_tvalid   = 1'b0;
  logic [7:0]           s_tdata    = '0;
  logic                 s_tready;
  logic                 m_tvalid;
  logic                 m_tready   = 1'b0;
  logic [47:0]          m_tdata;

  bit                   rx_steady  = 1'b0;
  int                   n_settings = 1;
  plant_tracker         sb;

  heater_thermal_plant_step_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Writes all three registers on consecutive edges while the plant is idle.
  task automatic load_plant(int amb, int mass_v, int tick);
    logic [CFG_W-1:0] w;
    logic [3:0]       hi;
    hi = 4'($urandom_range(0, 15));
    w  = {hi, 16'(amb)};
    cfg_we <= 1'b1; cfg_addr <= CFG_AMBIENT; cfg_wdata <= w;
    sb.set_reg(CFG_AMBIENT, w);
    @(posedge clk_i);
    hi = 4'($urandom_range(0, 15));
    w  = {hi, 16'(mass_v)};
    cfg_addr <= CFG_MASS; cfg_wdata <= w;
    sb.set_reg(CFG_MASS, w);
    @(posedge clk_i);
    w = 20'(tick);
    cfg_addr <= CFG_TICK; cfg_wdata <= w;
    sb.set_reg(CFG_TICK, w);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  task automatic settle();
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Offers n ticks; pct is the chance in percent that the drive pin is high.
  task automatic run_phase(int n, int pct, bit steady);
    int gap;
    bit pwm;
    rx_steady = steady;
    for (int i = 0; i < n; i++) begin
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pwm = ($urandom_range(0, 99) < pct);
      s_tvalid <= 1'b1;
      s_tdata  <= {7'd0, pwm};
      @(posedge clk_i);
      while (!s_tready) @(posedge clk_i);
      sb.advance_plant(pwm);
    end
    s_tvalid <= 1'b0;
  endtask

  initial begin
    int gap;
    int taken;
    taken = 0;
    wait (rst_n);
    @(posedge clk_i);
    forever begin
      if (taken == 150) begin
        m_tready <= 1'b0;
        repeat (500) @(posedge clk_i);
        gap = 0;
      end else begin
        gap = rx_steady ? 0 : $urandom_range(0, 9);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      sb.check_result(m_tdata);
      taken++;
    end
  end

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    run_phase(20, 50, 1'b0);
    settle();
    load_plant(-10240, 256, 1000000);
    run_phase(60, 5, 1'b1);
    settle();
    load_plant(25600, 0, 1048575);
    run_phase(80, 95, 1'b0);
    settle();
    load_plant(6400, 512, 0);
    run_phase(15, 50, 1'b0);
    settle();
    load_plant(0, 65535, 1);
    run_phase(20, 50, 1'b1);
    settle();
    load_plant(12800, 255, 500000);
    run_phase(30, 70, 1'b0);

    for (int p = 0; p < 8; p++) begin
      int amb, mass_v, tick;
      amb    = $urandom_range(0, 35840) - 10240;
      mass_v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 65535);
      if ($urandom_range(0, 9) == 0) tick = 0;
      else if ($urandom_range(0, 1)) tick = $urandom_range(1, 1000);
      else tick = $urandom_range(1, 1000000);
      settle();
      load_plant(amb, mass_v, tick);
      run_phase(40, $urandom_range(0, 100), (p % 3) == 1);
    end

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Plant run: %0d ticks over %0d register settings, %0d readings checked.",
             sb.ticks_seen, n_settings, sb.readings_seen);
    $display("Settings spanned cold, hot, zero-period, minimum and maximum mass plants.");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- heater_thermal_plant_step_core.f -----
src/htps_pkg.sv
src/heater_thermal_plant_step.sv
bench/heater_thermal_plant_step_core_tb.sv
